// File: rtl/brq_pkg.sv
// Shared constants and codes for the byte ring queue.
`timescale 1ns / 1ps

package brq_pkg;

  localparam int DEPTH_DEF     = 4096;
  localparam int MAX_BURST_DEF = 64;

  localparam int BYTE_W   = 8;
  localparam int OP_W     = 3;
  localparam int LEN_W    = 12;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

  // Request operations
  localparam logic [OP_W-1:0] OP_PUSH_BEGIN = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BYTE  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP        = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd3;
  localparam logic [OP_W-1:0] OP_DROP       = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROP_BIG = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_CHUNK = 3'd4;

endpackage

// File: rtl/brq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module brq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/byte_ring_queue_with_chunk_admission_unit.sv
// Top level of the byte ring queue with chunk admission.
`timescale 1ns / 1ps

// Byte FIFO held in a ring RAM of DEPTH bytes. Each request carries an op:
// push_begin announces a chunk and admits it whole only when
// length + fill + 1 is below min(queue_limit, DEPTH); push_byte stores one
// byte of the open chunk; pop and peek return min(request_len, fill,
// MAX_BURST) bytes, one result each (pop also advances the head); drop
// advances the head when the count fits within the fill level; clear empties
// the queue. Push_begin, push_byte, drop and clear each give exactly one result;
// op codes 6 and 7 give none. Timing: a request is accepted once the previous
// request's last result is taken (the same cycle is fine), so push, drop and
// clear run at one request per cycle while the result side does not stall. Pop and
// peek stream their bytes at one per cycle, when not stalled, from the single
// registered RAM read port: the first byte appears the cycle after the request
// is accepted, and a pop holds the request side until its last byte is taken.
// The RAM needs no clearing pass after reset; only bytes inside the queue are
// ever read. queue_limit is written through cfg_wr_en / cfg_wr_data; the user
// must do so only while the block is idle, which the block does not enforce.
module byte_ring_queue_with_chunk_admission_unit #(
  parameter int DEPTH     = brq_pkg::DEPTH_DEF,
  parameter int MAX_BURST = brq_pkg::MAX_BURST_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [brq_pkg::LIMIT_W-1:0]   cfg_wr_data,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [brq_pkg::OP_W-1:0]      op,
  input  logic [brq_pkg::BYTE_W-1:0]    data_byte,
  input  logic [brq_pkg::LEN_W-1:0]     request_len,
  // result channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [brq_pkg::BYTE_W-1:0]    out_byte,
  output logic                          last,
  output logic [brq_pkg::STATUS_W-1:0]  status,
  output logic [brq_pkg::LEN_W-1:0]     count
);

  import brq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(MAX_BURST + 1);
  localparam int CW = (AW > LEN_W) ? AW : LEN_W;
  localparam int SW = ((AW + 1 > LIMIT_W) ? AW + 1 : LIMIT_W) + 1;
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);

  // Queue state
  logic [AW-1:0]      head, tail, fill;
  logic [LEN_W-1:0]   chunk_rem;
  logic               chunk_open;
  logic [LIMIT_W-1:0] queue_limit;

  // Next values
  logic [AW-1:0]      head_next, tail_next, fill_next;
  logic [LEN_W-1:0]   chunk_rem_next;
  logic               chunk_open_next;

  // Burst read control
  logic [NW-1:0]      burst_left;
  logic [AW-1:0]      rd_ptr;

  // Output stage
  logic               out_is_data;
  logic [BYTE_W-1:0]  ram_rdata;

  // Per-request decode
  logic               req_acc, rsp_take;
  logic [SW-1:0]      lim_w, need_w;
  logic               admit, drop_ok;
  logic [CW-1:0]      len_c, fill_c, n_min, n_cap;
  logic [NW-1:0]      n;
  logic [AW-1:0]      adv_amt, head_adv;
  logic [AW:0]        head_sum;
  logic [AW+LEN_W-1:0] fill_wide;

  logic               res_valid, res_is_data, res_last, res_cnt_n;
  logic [STATUS_W-1:0] res_status;
  logic [LEN_W-1:0]   res_count;
  logic               start_burst, ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_IX) ? '0 : p + 1'b1;
  endfunction

  // Handshakes. Hold off requests while a burst streams or a result is stuck.
  assign req_stall = (burst_left != '0) || (rsp_valid && rsp_stall);
  assign req_acc   = req_valid && !req_stall;
  assign rsp_take  = rsp_valid && !rsp_stall;

  // Admission: length + fill + 1 < min(limit, DEPTH)
  assign lim_w  = (SW'(queue_limit) < SW'(DEPTH)) ? SW'(queue_limit) : SW'(DEPTH);
  assign need_w = SW'(request_len) + SW'(fill) + SW'(1);
  assign admit  = need_w < lim_w;

  // Burst length: min(request, fill, MAX_BURST)
  assign len_c   = CW'(request_len);
  assign fill_c  = CW'(fill);
  assign n_min   = (len_c < fill_c) ? len_c : fill_c;
  assign n_cap   = (n_min > CW'(MAX_BURST)) ? CW'(MAX_BURST) : n_min;
  assign n       = NW'(n_cap);
  assign drop_ok = len_c <= fill_c;

  // Head advance for pop and drop; amount never exceeds the fill level
  assign adv_amt  = (op == OP_DROP) ? AW'(len_c) : AW'(n);
  assign head_sum = {1'b0, head} + {1'b0, adv_amt};
  assign head_adv = (head_sum >= DEPTH_X) ? AW'(head_sum - DEPTH_X) : AW'(head_sum);

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    fill_next       = fill;
    chunk_rem_next  = chunk_rem;
    chunk_open_next = chunk_open;
    res_valid       = 1'b0;
    res_is_data     = 1'b0;
    res_last        = 1'b1;
    res_cnt_n       = 1'b0;
    res_status      = ST_OK;
    start_burst     = 1'b0;
    ram_we          = 1'b0;
    unique case (op)
      OP_PUSH_BEGIN: begin
        res_valid       = 1'b1;
        chunk_rem_next  = '0;
        chunk_open_next = 1'b0;
        if (admit) begin
          chunk_rem_next  = request_len;
          chunk_open_next = request_len != '0;
        end else begin
          res_status = ST_NO_ROOM;
        end
      end
      OP_PUSH_BYTE: begin
        res_valid = 1'b1;
        if (!chunk_open || chunk_rem == '0) begin
          res_status = ST_NO_CHUNK;
        end else begin
          ram_we          = 1'b1;
          tail_next       = ptr_inc(tail);
          fill_next       = fill + 1'b1;
          chunk_rem_next  = chunk_rem - 1'b1;
          chunk_open_next = chunk_rem != LEN_W'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        res_valid = 1'b1;
        res_cnt_n = 1'b1;
        if (fill == '0) begin
          res_status = ST_EMPTY;
        end else if (n != '0) begin
          start_burst = 1'b1;
          res_is_data = 1'b1;
          res_last    = n == NW'(1);
          if (op == OP_POP) begin
            head_next = head_adv;
            fill_next = fill - AW'(n);
          end
        end
      end
      OP_DROP: begin
        res_valid = 1'b1;
        if (drop_ok) begin
          head_next = head_adv;
          fill_next = fill - AW'(len_c);
        end else begin
          res_status = ST_DROP_BIG;
        end
      end
      OP_CLEAR: begin
        res_valid       = 1'b1;
        head_next       = '0;
        tail_next       = '0;
        fill_next       = '0;
        chunk_rem_next  = '0;
        chunk_open_next = 1'b0;
      end
      default: begin
      end
    endcase
    // Fill level after the op, cut to the count width
    fill_wide = (AW + LEN_W)'(fill_next);
    res_count = res_cnt_n ? LEN_W'(n) : fill_wide[LEN_W-1:0];
  end

  // Reads come from a pop/peek start or a taken byte with more to go. Writes
  // only happen on an accepted push_byte, which never shares a cycle with a
  // read, so the same entry is never read and written at once.
  assign ram_re    = (req_acc && start_burst) || (rsp_take && burst_left != '0);
  assign ram_raddr = (burst_left != '0) ? rd_ptr : head;

  brq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (req_acc && ram_we),
    .wr_addr (tail),
    .wr_data (data_byte),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Bytes come straight from the RAM's read register, which holds under stall
  assign out_byte = out_is_data ? ram_rdata : '0;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      fill        <= '0;
      chunk_rem   <= '0;
      chunk_open  <= 1'b0;
      queue_limit <= LIMIT_RESET;
      rsp_valid   <= 1'b0;
      burst_left  <= '0;
      rd_ptr      <= '0;
    end else begin
      if (cfg_wr_en) begin
        queue_limit <= cfg_wr_data;
      end
      if (req_acc) begin
        head       <= head_next;
        tail       <= tail_next;
        fill       <= fill_next;
        chunk_rem  <= chunk_rem_next;
        chunk_open <= chunk_open_next;
        rsp_valid  <= res_valid;
        if (start_burst) begin
          burst_left <= n - 1'b1;
          rd_ptr     <= ptr_inc(head);
        end
      end else if (rsp_take) begin
        if (burst_left != '0) begin
          // Advance to the next byte of the burst
          burst_left <= burst_left - 1'b1;
          rd_ptr     <= ptr_inc(rd_ptr);
        end else begin
          rsp_valid <= 1'b0;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (req_acc && res_valid) begin
      out_is_data <= res_is_data;
      last        <= res_last;
      status      <= res_status;
      count       <= res_count;
    end else if (rsp_take && burst_left != '0) begin
      last <= burst_left == NW'(1);
    end
  end

endmodule

// File: sim/byte_ring_queue_with_chunk_admission_unit_tb.sv
// Self-checking testbench for the byte ring queue with chunk admission unit.
`timescale 1ns / 1ps

module byte_ring_queue_with_chunk_admission_unit_tb;
  import brq_pkg::*;

  localparam int RING_DEPTH   = DEPTH_DEF;
  localparam int BURST_MAX    = MAX_BURST_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  // Quiet cycles before a limit write, and after the last result at the end
  localparam int CFG_DRAIN    = 8;
  localparam int END_DRAIN    = 20;
  // Window with no idling on either side
  localparam int STEADY_START = 400;
  localparam int STEADY_END   = 1200;
  localparam int PHASE_ITEMS  = 60;

  // Op codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // One entry of the stimulus list: a request or a limit write
  typedef struct {
    bit                  is_limit;
    logic [LIMIT_W-1:0]  limit;
    logic [OP_W-1:0]     op;
    logic [BYTE_W-1:0]   data;
    logic [LEN_W-1:0]    len;
  } brq_request_t;

  typedef struct {
    logic [BYTE_W-1:0]   out_byte;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    count;
  } brq_result_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_wr_en   = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wr_data = '0;
  logic                 req_valid   = 1'b0;
  logic                 req_stall;
  logic [OP_W-1:0]      op          = '0;
  logic [BYTE_W-1:0]    data_byte   = '0;
  logic [LEN_W-1:0]     request_len = '0;
  logic                 rsp_valid;
  logic                 rsp_stall   = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 last;
  logic [STATUS_W-1:0]  status;
  logic [LEN_W-1:0]     count;

  brq_request_t pending_requests[$];
  brq_result_t  expected_results[$];
  brq_result_t  observed_results[$];
  brq_request_t on_bus;
  int           mismatches = 0;
  int           cyc = 0;
  int           quiet_cycles = 0;

  // Shadow copy of the queue contents and pointers
  logic [BYTE_W-1:0] mirror_bytes [0:RING_DEPTH-1];
  int unsigned       mirror_head = 0;
  int unsigned       mirror_tail = 0;
  int unsigned       mirror_fill = 0;
  int unsigned       mirror_chunk_left = 0;
  bit                mirror_chunk_open = 1'b0;
  int unsigned       mirror_limit = LIMIT_RESET;

  byte_ring_queue_with_chunk_admission_unit uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .op          (op),
    .data_byte   (data_byte),
    .request_len (request_len),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .out_byte    (out_byte),
    .last        (last),
    .status      (status),
    .count       (count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the results of one accepted request and advance the shadow state.
  task automatic predict_queue_op(input brq_request_t rq);
    int unsigned lim;
    int unsigned n;
    int unsigned pos;
    brq_result_t r;
    lim = (mirror_limit < RING_DEPTH) ? mirror_limit : RING_DEPTH;
    r.out_byte = '0;
    r.last     = 1'b1;
    r.status   = ST_OK;
    r.count    = '0;
    case (rq.op)
      OP_PUSH_BEGIN: begin
        // A new announcement always gives up the bytes still owed by an open chunk
        mirror_chunk_left = 0;
        mirror_chunk_open = 1'b0;
        if (rq.len + mirror_fill + 1 < lim) begin
          mirror_chunk_left = rq.len;
          mirror_chunk_open = (rq.len != 0);
        end else begin
          r.status = ST_NO_ROOM;
        end
        r.count = LEN_W'(mirror_fill);
        expected_results.push_back(r);
      end
      OP_PUSH_BYTE: begin
        if (!mirror_chunk_open || mirror_chunk_left == 0) begin
          r.status = ST_NO_CHUNK;
        end else begin
          mirror_bytes[mirror_tail] = rq.data;
          mirror_tail = (mirror_tail + 1) % RING_DEPTH;
          mirror_fill++;
          mirror_chunk_left--;
          if (mirror_chunk_left == 0) mirror_chunk_open = 1'b0;
        end
        r.count = LEN_W'(mirror_fill);
        expected_results.push_back(r);
      end
      OP_POP, OP_PEEK: begin
        if (mirror_fill == 0) begin
          r.status = ST_EMPTY;
          expected_results.push_back(r);
        end else begin
          n = (rq.len < mirror_fill) ? rq.len : mirror_fill;
          if (n > BURST_MAX) n = BURST_MAX;
          if (n == 0) begin
            expected_results.push_back(r);
          end else begin
            pos = mirror_head;
            for (int i = 0; i < n; i++) begin
              r.out_byte = mirror_bytes[pos];
              r.last     = (i + 1 == n);
              r.count    = LEN_W'(n);
              expected_results.push_back(r);
              pos = (pos + 1) % RING_DEPTH;
            end
            // Only pop consumes; peek leaves the head where it was
            if (rq.op == OP_POP) begin
              mirror_head = pos;
              mirror_fill -= n;
            end
          end
        end
      end
      OP_DROP: begin
        if (rq.len <= mirror_fill) begin
          mirror_head = (mirror_head + rq.len) % RING_DEPTH;
          mirror_fill -= rq.len;
        end else begin
          r.status = ST_DROP_BIG;
        end
        r.count = LEN_W'(mirror_fill);
        expected_results.push_back(r);
      end
      OP_CLEAR: begin
        mirror_head       = 0;
        mirror_tail       = 0;
        mirror_fill       = 0;
        mirror_chunk_left = 0;
        mirror_chunk_open = 1'b0;
        expected_results.push_back(r);
      end
      default: begin
        // Spare op codes: no result, no state change
      end
    endcase
  endtask

  task automatic add_request(input logic [OP_W-1:0] code, input logic [BYTE_W-1:0] value,
                             input logic [LEN_W-1:0] len);
    brq_request_t rq;
    rq.is_limit = 1'b0;
    rq.limit    = '0;
    rq.op       = code;
    rq.data     = value;
    rq.len      = len;
    pending_requests.push_back(rq);
  endtask

  task automatic add_limit(input logic [LIMIT_W-1:0] value);
    brq_request_t rq;
    rq.is_limit = 1'b1;
    rq.limit    = value;
    rq.op       = OP_CLEAR;
    rq.data     = '0;
    rq.len      = '0;
    pending_requests.push_back(rq);
  endtask

  // Queue a run of push_byte requests with random content
  task automatic add_bytes(input int n);
    for (int i = 0; i < n; i++)
      add_request(OP_PUSH_BYTE, BYTE_W'($urandom_range(0, 255)),
                  LEN_W'($urandom_range(0, 4095)));
  endtask

  // Free-running cycle count; also the watchdog for a hung run.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Request driver: predict each accepted request at its accepting edge, then
  // present the next pending request or limit write. Hold the payload while
  // the block stalls; lower valid only after an accept or while idle.
  always @(posedge clk) begin : drive_requests
    bit           accepted;
    bit           idle_now;
    logic         valid_next;
    logic         wr_next;
    brq_request_t nxt;
    if (!rst) begin
      accepted   = req_valid && !req_stall;
      idle_now   = (cyc >= STEADY_START && cyc < STEADY_END) ? 1'b0
                                                              : ($urandom_range(0, 99) < 30);
      if (accepted) predict_queue_op(on_bus);
      // Count cycles with neither side moving, so limit writes land on an idle block
      if (req_valid || rsp_valid) quiet_cycles = 0;
      else quiet_cycles++;
      valid_next = req_valid && !accepted;
      wr_next    = 1'b0;
      if (!valid_next && pending_requests.size() != 0) begin
        nxt = pending_requests[0];
        if (nxt.is_limit) begin
          // Write the limit only when every result is in and the block has gone quiet
          if (!cfg_wr_en && expected_results.size() == 0 && quiet_cycles >= CFG_DRAIN) begin
            void'(pending_requests.pop_front());
            wr_next      = 1'b1;
            cfg_wr_data <= nxt.limit;
            mirror_limit = nxt.limit;
          end
        end else if (!idle_now) begin
          void'(pending_requests.pop_front());
          on_bus       = nxt;
          valid_next   = 1'b1;
          op          <= nxt.op;
          data_byte   <= nxt.data;
          request_len <= nxt.len;
        end
      end
      req_valid <= valid_next;
      cfg_wr_en <= wr_next;
    end
  end

  // Result monitor: capture each accepted result, compare the oldest capture
  // with the oldest prediction, and drive the result-side stall.
  always @(posedge clk) begin : watch_results
    brq_result_t got;
    brq_result_t want;
    if (!rst) begin
      // Compare one pair per cycle; captures arrive at most one per cycle
      if (observed_results.size() != 0 && expected_results.size() != 0) begin
        got  = observed_results.pop_front();
        want = expected_results.pop_front();
        if (got.out_byte !== want.out_byte || got.last !== want.last ||
            got.status !== want.status || got.count !== want.count) begin
          mismatches++;
          $display("%0t: result mismatch: expected byte %02h last %0b status %0d count %0d",
                   $time, want.out_byte, want.last, want.status, want.count);
          $display("%0t:                  actual   byte %02h last %0b status %0d count %0d",
                   $time, got.out_byte, got.last, got.status, got.count);
        end
      end
      if (rsp_valid && !rsp_stall) begin
        got.out_byte = out_byte;
        got.last     = last;
        got.status   = status;
        got.count    = count;
        observed_results.push_back(got);
      end
      rsp_stall <= (cyc >= STEADY_START && cyc < STEADY_END) ? 1'b0
                                                              : ($urandom_range(0, 99) < 30);
    end
  end

  initial begin : run_test
    logic [LIMIT_W-1:0] limit_plan [0:5];
    logic [LEN_W-1:0]   len;
    int                 pick;
    int                 made;
    int                 nbytes;
    logic [OP_W-1:0]    noise_op;

    // Directed opening at the reset limit
    add_request(OP_POP, 8'h00, 12'd5);              // empty queue
    add_request(OP_PEEK, 8'hFF, 12'd0);             // empty queue
    add_request(OP_PUSH_BYTE, 8'h11, 12'd0);        // stray byte, no chunk
    add_request(OP_PUSH_BEGIN, 8'h00, 12'd0);       // zero-length chunk leaves nothing open
    add_request(OP_PUSH_BYTE, 8'h22, 12'hFFF);      // still stray
    add_request(OP_PUSH_BEGIN, 8'hFF, 12'd3);
    add_request(OP_PUSH_BYTE, 8'h00, 12'd0);
    add_request(OP_PUSH_BYTE, 8'hFF, 12'hFFF);
    add_request(OP_PUSH_BYTE, 8'hA5, 12'h555);
    add_request(OP_PUSH_BYTE, 8'h5A, 12'hAAA);      // one byte past the chunk
    add_request(OP_PEEK, 8'h00, 12'd0);             // zero count on a non-empty queue
    add_request(OP_PEEK, 8'h00, 12'hFFF);           // capped by the fill level
    add_request(OP_POP, 8'h00, 12'd2);
    add_request(OP_DROP, 8'h00, 12'hFFF);           // drop beyond the fill level
    add_request(OP_DROP, 8'h00, 12'd1);
    add_request(OP_PUSH_BEGIN, 8'h00, 12'hFFF);     // no room at any fill
    add_request(OP_PUSH_BEGIN, 8'h00, 12'd4);
    add_request(OP_PUSH_BYTE, 8'h3C, 12'd0);
    add_request(OP_PUSH_BEGIN, 8'h00, 12'd2);       // abandon the open chunk
    add_bytes(2);
    add_request(OP_SPARE_6, 8'hFF, 12'hFFF);        // ignored, no result
    add_request(OP_SPARE_7, 8'h00, 12'd0);          // ignored, no result
    add_request(OP_DROP, 8'h00, 12'd0);
    add_request(OP_CLEAR, 8'h00, 12'd0);

    // Random phases over several limits: smallest legal, small, random, mid,
    // below two (every chunk refused) and the widest register value
    limit_plan[0] = 13'd3;
    limit_plan[1] = 13'd40;
    limit_plan[2] = LIMIT_W'($urandom_range(3, 4096));
    limit_plan[3] = 13'd500;
    limit_plan[4] = 13'd1;
    limit_plan[5] = 13'h1FFF;
    for (int p = 0; p < 6; p++) begin
      add_limit(limit_plan[p]);
      made = 0;
      while (made < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          // Mostly well-formed chunks; some cut short or overrun
          if (pick < 35) len = LEN_W'($urandom_range(0, 12));
          else if (pick < 47) len = LEN_W'($urandom_range(0, 100));
          else len = LEN_W'($urandom_range(0, 4095));
          add_request(OP_PUSH_BEGIN, BYTE_W'($urandom_range(0, 255)), len);
          if (len > 100) nbytes = $urandom_range(0, 3);
          else begin
            case ($urandom_range(0, 9))
              0:       nbytes = $urandom_range(0, len);
              1:       nbytes = len + $urandom_range(1, 3);
              default: nbytes = len;
            endcase
          end
          add_bytes(nbytes);
          made += 1 + nbytes;
        end else if (pick < 80) begin
          len = ($urandom_range(0, 99) < 85) ? LEN_W'($urandom_range(0, 70))
                                             : LEN_W'($urandom_range(0, 4095));
          add_request((pick < 68) ? OP_POP : OP_PEEK, BYTE_W'($urandom_range(0, 255)), len);
          made++;
        end else if (pick < 90) begin
          len = ($urandom_range(0, 99) < 85) ? LEN_W'($urandom_range(0, 20))
                                             : LEN_W'($urandom_range(0, 4095));
          add_request(OP_DROP, BYTE_W'($urandom_range(0, 255)), len);
          made++;
        end else if (pick < 93) begin
          add_request(OP_CLEAR, BYTE_W'($urandom_range(0, 255)),
                      LEN_W'($urandom_range(0, 4095)));
          made++;
        end else begin
          // Noise: any op code, spare ones included
          noise_op = OP_W'($urandom_range(0, 7));
          add_request(noise_op, BYTE_W'($urandom_range(0, 255)),
                      LEN_W'($urandom_range(0, 4095)));
          if (noise_op != OP_SPARE_6 && noise_op != OP_SPARE_7) made++;
        end
      end
    end

    // Fill to the top at a small limit: the last free slot is never granted
    add_limit(13'd10);
    add_request(OP_CLEAR, 8'h00, 12'd0);
    add_request(OP_PUSH_BEGIN, 8'h00, 12'd8);
    add_bytes(8);
    add_request(OP_PUSH_BEGIN, 8'h00, 12'd0);       // fits exactly at the top
    add_request(OP_PUSH_BEGIN, 8'h00, 12'd1);       // one more is refused
    add_request(OP_PUSH_BYTE, 8'hEE, 12'd0);
    add_request(OP_PEEK, 8'h00, 12'hFFF);
    add_request(OP_POP, 8'h00, 12'd3);
    add_request(OP_DROP, 8'h00, 12'd2);
    add_request(OP_POP, 8'h00, 12'hFFF);
    add_request(OP_POP, 8'h00, 12'd1);              // empty again

    // Hold reset, then let the driver and monitor run
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || req_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);
    if (observed_results.size() != 0) begin
      mismatches++;
      $display("%0t: expected no further result, actual %0d extra results", $time,
               observed_results.size());
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
